### sv/lkv_pkg.sv
// shared types and constants of the lru key/value cache
`default_nettype none

package lkv_pkg;

    // sizes
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int KEY_BITS        = 64;
    localparam int VALUE_BITS      = 32;
    localparam int CAP_BITS        = 5;

    // configuration port
    localparam int                  ADDR_BITS     = 3;
    localparam int                  DATA_BITS     = 32;
    localparam logic                REG_CAPACITY  = 1'b0;
    localparam logic [CAP_BITS-1:0] CAP_RESET     = 5'd16;

    // operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // request word
    typedef struct packed {
        logic                  func;
        logic [KEY_BITS-1:0]   key_tag;
        logic [VALUE_BITS-1:0] value_handle;
    } t_req;

    // result word
    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
    } t_rsp;

    // entry store controls
    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic val_we;
    } t_store_cmd;

endpackage

`default_nettype wire

### sv/lkv_order_mem.sv
// recency order memory: slot numbers, least recent first
`default_nettype none

module lkv_order_mem #(
    parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES,
    localparam int PW = $clog2(MAX_ENTRIES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [PW-1:0] i_rd_addr,
    output logic      [PW-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [PW-1:0] i_wr_addr,
    input  wire logic [PW-1:0] i_wr_data
);

    logic [PW-1:0] r_mem [MAX_ENTRIES];
    logic [PW-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### sv/lkv_entry_store.sv
// key and value memories with the shared key comparator
`default_nettype none

module lkv_entry_store #(
    parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES,
    localparam int PW = $clog2(MAX_ENTRIES)
) (
    input  wire logic                            i_clk,
    input  wire lkv_pkg::t_store_cmd             i_cmd,
    input  wire logic [PW-1:0]                   i_rd_slot,
    input  wire logic [PW-1:0]                   i_wr_slot,
    input  wire logic [lkv_pkg::KEY_BITS-1:0]    i_key,
    input  wire logic [lkv_pkg::VALUE_BITS-1:0]  i_value,
    output logic                                 o_match,
    output logic      [lkv_pkg::VALUE_BITS-1:0]  o_value
);

    logic [lkv_pkg::KEY_BITS-1:0]   r_key_mem [MAX_ENTRIES];
    logic [lkv_pkg::VALUE_BITS-1:0] r_val_mem [MAX_ENTRIES];
    logic [lkv_pkg::KEY_BITS-1:0]   r_key_q;
    logic [lkv_pkg::VALUE_BITS-1:0] r_val_q;

    // writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_we) begin
            r_key_mem[i_wr_slot] <= i_key;
        end
        if (i_cmd.val_we) begin
            r_val_mem[i_wr_slot] <= i_value;
        end
        if (i_cmd.rd_en) begin
            r_key_q <= r_key_mem[i_rd_slot];
            r_val_q <= r_val_mem[i_rd_slot];
        end
    end

    // one comparator shared by every step of the walk
    assign o_match = (r_key_q == i_key);
    assign o_value = r_val_q;

endmodule

`default_nettype wire

### sv/lkv_seq.sv
// sequencer: walks the recency order, then updates it on a hit, an insert or an eviction
`default_nettype none

module lkv_seq #(
    parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire lkv_pkg::t_req                 i_req,
    input  wire logic [lkv_pkg::CAP_BITS-1:0]  i_cap,
    output logic                               o_busy,
    output logic                               o_done,
    output lkv_pkg::t_rsp                      o_rsp
);

    localparam int PW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic          r_v1, r_v2, r_wv, r_found;

    lkv_pkg::t_req r_req;
    lkv_pkg::t_rsp r_rsp;
    logic [CW-1:0] r_pi, r_rp;
    logic [PW-1:0] r_pos1, r_pos2, r_slot2, r_wp;
    logic [PW-1:0] r_hit_pos, r_hit_slot, r_first_slot, r_mv_slot;
    logic [lkv_pkg::VALUE_BITS-1:0] r_hit_val;

    logic                    accept, issue_walk, issue_shift, walk_end, shift_end;
    logic                    hit_now, full, do_shift;
    logic [CW-1:0]           eff_cap, last_pos;
    logic                    ord_rd_en, ord_wr_en;
    logic [PW-1:0]           ord_rd_addr, ord_rd_data, ord_wr_addr, ord_wr_data;
    lkv_pkg::t_store_cmd     st_cmd;
    logic [PW-1:0]           st_wr_slot;
    logic                    st_match;
    logic [lkv_pkg::VALUE_BITS-1:0] st_value;

    // effective capacity: zero reads as one, saturated to the depth
    always_comb begin
        if (i_cap == '0) begin
            eff_cap = CW'(1);
        end else if (32'(i_cap) > 32'(MAX_ENTRIES)) begin
            eff_cap = CW'(MAX_ENTRIES);
        end else begin
            eff_cap = CW'(i_cap);
        end
    end

    // sequencing conditions
    assign accept      = i_start && (r_state == S_IDLE);
    assign issue_walk  = (r_state == S_WALK) && (r_pi < r_cnt) && !r_found;
    assign issue_shift = (r_state == S_SHIFT) && (r_rp < r_cnt);
    assign walk_end    = (r_state == S_WALK) && !issue_walk && !r_v1 && !r_v2;
    assign shift_end   = (r_state == S_SHIFT) && !issue_shift && !r_wv;
    assign hit_now     = r_v2 && st_match && !r_found;
    assign full        = (r_cnt >= eff_cap);
    assign do_shift    = r_found || ((r_req.func == lkv_pkg::FUNC_PUT) && full);
    assign last_pos    = r_cnt - CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (r_cnt == '0) ? S_DECIDE : S_WALK;
                end
            end
            S_WALK: begin
                if (walk_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = do_shift ? S_SHIFT : S_IDLE;
            end
            S_SHIFT: begin
                if (shift_end) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // order memory port selection
    always_comb begin
        ord_rd_en   = issue_walk || issue_shift;
        ord_rd_addr = issue_walk ? r_pi[PW-1:0] : r_rp[PW-1:0];
        ord_wr_en   = 1'b0;
        ord_wr_addr = r_wp;
        ord_wr_data = ord_rd_data;
        priority if (r_state == S_SHIFT && r_wv) begin
            ord_wr_en = 1'b1;
        end else if (r_state == S_FINAL) begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = last_pos[PW-1:0];
            ord_wr_data = r_mv_slot;
        end else if (r_state == S_DECIDE && !r_found
                     && r_req.func == lkv_pkg::FUNC_PUT && !full) begin
            // insert: the free slot at the end of the order is its own number
            ord_wr_en   = 1'b1;
            ord_wr_addr = r_cnt[PW-1:0];
            ord_wr_data = r_cnt[PW-1:0];
        end else begin
            ord_wr_en = 1'b0;
        end
    end

    // entry store controls
    always_comb begin
        st_cmd.rd_en  = r_v1;
        st_cmd.key_we = 1'b0;
        st_cmd.val_we = 1'b0;
        st_wr_slot    = r_hit_slot;
        if (r_state == S_DECIDE && r_req.func == lkv_pkg::FUNC_PUT) begin
            priority if (r_found) begin
                st_cmd.val_we = 1'b1;
            end else if (full) begin
                st_cmd.key_we = 1'b1;
                st_cmd.val_we = 1'b1;
                st_wr_slot    = r_first_slot;
            end else begin
                st_cmd.key_we = 1'b1;
                st_cmd.val_we = 1'b1;
                st_wr_slot    = r_cnt[PW-1:0];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_wv    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (n_state == S_IDLE) && (r_state != S_IDLE);
            r_v1    <= issue_walk;
            r_v2    <= r_v1;
            r_wv    <= issue_shift;
            if (accept) begin
                r_found <= 1'b0;
            end else if (hit_now) begin
                r_found <= 1'b1;
            end
            if (r_state == S_DECIDE && !r_found
                && r_req.func == lkv_pkg::FUNC_PUT && !full) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // walk pipeline and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_pi  <= '0;
        end else if (issue_walk) begin
            r_pi <= r_pi + CW'(1);
        end
        r_pos1  <= r_pi[PW-1:0];
        r_pos2  <= r_pos1;
        r_slot2 <= ord_rd_data;
        if (hit_now) begin
            r_hit_pos  <= r_pos2;
            r_hit_slot <= r_slot2;
            r_hit_val  <= st_value;
        end
        if (r_v2 && r_pos2 == '0) begin
            r_first_slot <= r_slot2;
        end
        if (r_state == S_DECIDE) begin
            r_rsp.hit        <= r_found;
            r_rsp.read_value <= (r_found && r_req.func == lkv_pkg::FUNC_GET)
                                ? r_hit_val : '0;
            r_rsp.evicted    <= !r_found && (r_req.func == lkv_pkg::FUNC_PUT) && full;
            if (r_found) begin
                r_mv_slot <= r_hit_slot;
                r_rp      <= CW'(r_hit_pos) + CW'(1);
            end else begin
                r_mv_slot <= r_first_slot;
                r_rp      <= CW'(1);
            end
        end else if (issue_shift) begin
            r_rp <= r_rp + CW'(1);
        end
        r_wp <= r_rp[PW-1:0] - PW'(1);
    end

    lkv_order_mem #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_order (
        .i_clk     (i_clk),
        .i_rd_en   (ord_rd_en),
        .i_rd_addr (ord_rd_addr),
        .o_rd_data (ord_rd_data),
        .i_wr_en   (ord_wr_en),
        .i_wr_addr (ord_wr_addr),
        .i_wr_data (ord_wr_data)
    );

    lkv_entry_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_cmd     (st_cmd),
        .i_rd_slot (ord_rd_data),
        .i_wr_slot (st_wr_slot),
        .i_key     (r_req.key_tag),
        .i_value   (r_req.value_handle),
        .o_match   (st_match),
        .o_value   (st_value)
    );

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

### sv/lru_key_value_cache_top.sv
// top level of the lru key/value cache with its configuration port
//
// Fully associative key/value cache with least-recently-used replacement.
// A request word (func, key_tag, value_handle) is taken at a clock edge with
// start high and busy low. func get looks the key up; func put updates or
// inserts it, evicting the least recent entry when the cache is full.
// One result word (hit, read_value, evicted) follows per request: o_done is
// high for exactly one cycle with o_rsp valid; the receiver cannot stall it.
// A miss walks the whole recency order through one key comparator, one
// entry per cycle, behind the order memory read and the entry store key
// read, then passes the decide state and returns the result.
// A hit or an eviction then shifts the order one entry per cycle and writes
// the moved slot back in the final state. An empty cache skips the walk.
// busy stays high for the whole operation; one request at a time.
// The capacity register (byte address 0) is written through the apb port;
// the user must write it only while the block is idle, which the block
// itself does not enforce. It resets to 16. Reset empties the cache
// (entry count zero); no clearing pass is needed.
`default_nettype none

module lru_key_value_cache_top #(
    parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire lkv_pkg::t_req                   i_req,
    output logic                                 o_done,
    output lkv_pkg::t_rsp                        o_rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lkv_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [lkv_pkg::DATA_BITS-1:0]   pwdata,
    output logic      [lkv_pkg::DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    logic [lkv_pkg::CAP_BITS-1:0] r_cap;
    logic                         cfg_wr;

    // capacity register write
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkv_pkg::CAP_RESET;
        end else if (cfg_wr && paddr[2] == lkv_pkg::REG_CAPACITY) begin
            r_cap <= pwdata[lkv_pkg::CAP_BITS-1:0];
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == lkv_pkg::REG_CAPACITY) begin
            prdata = lkv_pkg::DATA_BITS'(r_cap);
        end
    end

    assign pready = 1'b1;

    lkv_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .i_cap   (r_cap),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
